### rtl/core/bmhq_pkg.sv
// Shared constants for the binary min-heap queue: default sizes,
// request kinds and response status codes. No dependencies.
package bmhq_pkg;

   localparam int HEAP_DEPTH_DEF = 1024;
   localparam int KEY_BITS_DEF   = 32;
   localparam int HELD_W         = 11;
   localparam int STATUS_W       = 2;

   localparam logic REQ_INSERT  = 1'b0;
   localparam logic REQ_EXTRACT = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

### rtl/core/bmhq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module bmhq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/binary_min_heap_queue.sv
// Binary min-heap priority queue; keys live in one bmhq_ram instance.
// Depends on bmhq_pkg and bmhq_ram.
// Insert climbs: reads the parent and moves it down into the hole if larger,
// up to the root or a parent not larger. Extract reads the root, then the last
// key, and sinks it, reading both children of a level in turn (one port); with
// one key held it ends there. Errors (full insert, empty extract) go straight
// to the response. One request at a time; a full response register holds off the next.
// Reset is synchronous: it empties the heap and the response register; the
// key store is not cleared (slots are only read after they are written).
module binary_min_heap_queue
   import bmhq_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
   parameter int KEY_BITS   = KEY_BITS_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // [0] req_type: 0 insert, 1 extract
   input  logic                                     req_tuser,
   // key_value from bit 0, zero padded to whole bytes
   input  logic [((KEY_BITS+7)/8)*8-1:0]            req_tdata,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // min_key, status (2), entries_held (11), from bit 0 up, zero padded
   output logic [((KEY_BITS+STATUS_W+HELD_W+7)/8)*8-1:0] rsp_tdata
);

   localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
   localparam int ADDR_W = $clog2(HEAP_DEPTH);
   localparam int OUT_W  = ((KEY_BITS + STATUS_W + HELD_W + 7) / 8) * 8;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_UP_STEP  = 4'd1;
   localparam logic [3:0] ST_UP_CMP   = 4'd2;
   localparam logic [3:0] ST_EX_ROOT  = 4'd3;
   localparam logic [3:0] ST_EX_LAST  = 4'd4;
   localparam logic [3:0] ST_DN_STEP  = 4'd5;
   localparam logic [3:0] ST_DN_LEFT  = 4'd6;
   localparam logic [3:0] ST_DN_RIGHT = 4'd7;
   localparam logic [3:0] ST_DONE     = 4'd8;

   logic [3:0]          state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    pos_ff, pos_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [KEY_BITS-1:0] left_val_ff, left_val_in;
   logic [KEY_BITS-1:0] min_ff, min_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]    rsp_data_ff, rsp_data_in;

   logic                wr_en, rd_en;
   logic [CNT_W-1:0]    wr_slot, rd_slot, wr_slot_m1, rd_slot_m1;
   logic [KEY_BITS-1:0] wr_data, rd_data;
   logic [CNT_W-1:0]    parent;
   logic [CNT_W:0]      left_w, right_w, n_w;
   logic [KEY_BITS-1:0] cand_val;
   logic [CNT_W-1:0]    cand_pos;

   assign parent  = pos_ff >> 1;
   assign left_w  = {pos_ff, 1'b0};
   assign right_w = left_w + (CNT_W+1)'(1);
   assign n_w     = {1'b0, count_ff};

   assign wr_slot_m1 = wr_slot - CNT_W'(1);
   assign rd_slot_m1 = rd_slot - CNT_W'(1);

   bmhq_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (HEAP_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_slot_m1[ADDR_W-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_slot_m1[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // smaller child, left wins a tie
   always_comb begin
      if (rd_data < left_val_ff) begin
         cand_val = rd_data;
         cand_pos = right_w[CNT_W-1:0];
      end else begin
         cand_val = left_val_ff;
         cand_pos = left_w[CNT_W-1:0];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      key_in       = key_ff;
      left_val_in  = left_val_ff;
      min_in       = min_ff;
      status_in    = status_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_slot      = pos_ff;
      wr_data      = key_ff;
      rd_en        = 1'b0;
      rd_slot      = CNT_W'(1);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               min_in    = '0;
               status_in = STATUS_OK;
               key_in    = req_tdata[KEY_BITS-1:0];
               if (req_tuser == REQ_INSERT) begin
                  if (count_ff >= CNT_W'(HEAP_DEPTH)) begin
                     status_in = STATUS_FULL;
                     state_in  = ST_DONE;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                     pos_in   = count_ff + CNT_W'(1);
                     state_in = ST_UP_STEP;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = STATUS_EMPTY;
                     state_in  = ST_DONE;
                  end else begin
                     rd_en    = 1'b1;
                     rd_slot  = CNT_W'(1);
                     state_in = ST_EX_ROOT;
                  end
               end
            end
         end
         ST_UP_STEP: begin
            if (pos_ff == CNT_W'(1)) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_slot  = parent;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1;
            if (rd_data <= key_ff) begin
               state_in = ST_DONE;
            end else begin
               // move parent down into the hole
               wr_data  = rd_data;
               pos_in   = parent;
               state_in = ST_UP_STEP;
            end
         end
         ST_EX_ROOT: begin
            min_in   = rd_data;
            count_in = count_ff - CNT_W'(1);
            if (count_ff == CNT_W'(1)) begin
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_slot  = count_ff;
               state_in = ST_EX_LAST;
            end
         end
         ST_EX_LAST: begin
            key_in   = rd_data;
            pos_in   = CNT_W'(1);
            state_in = ST_DN_STEP;
         end
         ST_DN_STEP: begin
            if (left_w > n_w) begin
               wr_en    = 1'b1;
               state_in = ST_DONE;
            end else begin
               rd_en    = 1'b1;
               rd_slot  = left_w[CNT_W-1:0];
               state_in = ST_DN_LEFT;
            end
         end
         ST_DN_LEFT: begin
            left_val_in = rd_data;
            if (right_w <= n_w) begin
               rd_en    = 1'b1;
               rd_slot  = right_w[CNT_W-1:0];
               state_in = ST_DN_RIGHT;
            end else begin
               wr_en = 1'b1;
               if (rd_data < key_ff) begin
                  wr_data  = rd_data;
                  pos_in   = left_w[CNT_W-1:0];
                  state_in = ST_DN_STEP;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DN_RIGHT: begin
            wr_en = 1'b1;
            if (cand_val < key_ff) begin
               wr_data  = cand_val;
               pos_in   = cand_pos;
               state_in = ST_DN_STEP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            // hold until the response register frees up
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = OUT_W'({HELD_W'(count_ff), status_ff, min_ff});
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pos_ff      <= pos_in;
      key_ff      <= key_in;
      left_val_ff <= left_val_in;
      min_ff      <= min_in;
      status_ff   <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HEAP_DEPTH))
      else $error("heap count above depth");

   a_write_in_heap: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (wr_slot != '0 && wr_slot <= count_ff))
      else $error("store write outside the live heap");

   a_read_in_heap: assert property (@(posedge clock) disable iff (reset)
      rd_en |-> (rd_slot != '0 && rd_slot <= count_ff))
      else $error("store read outside the live heap");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |->
         ($past(state_ff) == ST_IDLE || $past(state_ff) == ST_EX_ROOT))
      else $error("heap count changed mid request");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && status_ff == STATUS_EMPTY) |-> (count_ff == '0))
      else $error("empty status with keys held");
`endif

endmodule

### bench/binary_min_heap_queue_test.sv
// Self-checking bench for binary_min_heap_queue: a directed table, then random
// insert/extract traffic scored against a min-heap kept inside the bench.
// Depends on bmhq_pkg and the binary_min_heap_queue RTL.
module binary_min_heap_queue_test;
   import bmhq_pkg::*;

   localparam int DEPTH       = HEAP_DEPTH_DEF;
   localparam int KEY_W       = KEY_BITS_DEF;
   localparam int REQ_W       = ((KEY_W+7)/8)*8;
   localparam int RSP_W       = ((KEY_W+STATUS_W+HELD_W+7)/8)*8;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int IDLE_PCT    = 34;

   typedef struct {
      logic [KEY_W-1:0]    min_key;
      logic [STATUS_W-1:0] status;
      logic [HELD_W-1:0]   held;
   } heap_rsp_type;

   typedef struct {
      logic             kind;
      logic [KEY_W-1:0] key;
      bit               typed;
      heap_rsp_type     rsp;
   } request_row_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic             req_tuser  = REQ_INSERT;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // bench copy of the heap, one-based
   logic [KEY_W-1:0] heap_keys [1:DEPTH];
   int               heap_size = 0;

   heap_rsp_type     rsp_due [$];
   request_row_type  directed_rows [$];
   int               mismatch_count = 0;
   int               cycle_count = 0;
   bit               no_gaps = 1'b0;

   binary_min_heap_queue #(
      .HEAP_DEPTH (DEPTH),
      .KEY_BITS   (KEY_W)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_tready <= no_gaps || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // Apply one request to the bench heap and return the response it causes.
   function automatic heap_rsp_type heap_apply(logic kind, logic [KEY_W-1:0] key);
      heap_rsp_type     r;
      int               pos;
      int               child;
      logic [KEY_W-1:0] moved;
      r.min_key = '0;
      r.status  = STATUS_OK;
      if (kind == REQ_INSERT) begin
         if (heap_size >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            heap_size++;
            pos = heap_size;
            // climb while the parent is strictly larger
            while (pos > 1 && heap_keys[pos/2] > key) begin
               heap_keys[pos] = heap_keys[pos/2];
               pos = pos / 2;
            end
            heap_keys[pos] = key;
         end
      end else if (heap_size == 0) begin
         r.status = STATUS_EMPTY;
      end else begin
         r.min_key = heap_keys[1];
         moved     = heap_keys[heap_size];
         heap_size--;
         pos = 1;
         // sink toward the smaller child; left wins a tie, equal keys stay put
         while (2 * pos <= heap_size) begin
            child = 2 * pos;
            if (child + 1 <= heap_size && heap_keys[child+1] < heap_keys[child])
               child = child + 1;
            if (heap_keys[child] >= moved)
               break;
            heap_keys[pos] = heap_keys[child];
            pos = child;
         end
         heap_keys[pos] = moved;
      end
      r.held = heap_size[HELD_W-1:0];
      return r;
   endfunction

   function automatic void add_row(logic kind, logic [KEY_W-1:0] key, bit typed = 1'b0,
                                   logic [KEY_W-1:0] min_key = '0,
                                   logic [STATUS_W-1:0] status = STATUS_OK,
                                   logic [HELD_W-1:0] held = '0);
      request_row_type row;
      row.kind        = kind;
      row.key         = key;
      row.typed       = typed;
      row.rsp.min_key = min_key;
      row.rsp.status  = status;
      row.rsp.held    = held;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0)
         return '0;
      else if (pick == 1)
         return '1;
      else if (pick < 5)
         return KEY_W'($urandom_range(0, 15));
      else
         return KEY_W'($urandom);
   endfunction

   // Drive one request, wait for it to be taken, record the response it is due.
   task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                               input bit typed, input heap_rsp_type typed_rsp);
      heap_rsp_type predicted;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= key;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = heap_apply(kind, key);
      if (typed)
         rsp_due.push_back(typed_rsp);
      else
         rsp_due.push_back(predicted);
      if (!no_gaps && $urandom_range(0, 99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(10, 40)) @(posedge clock);
         else
            repeat ($urandom_range(1, 3)) @(posedge clock);
      end
   endtask

   task automatic random_request(input int insert_pct);
      heap_rsp_type none;
      logic         kind;
      none.min_key = '0;
      none.status  = STATUS_OK;
      none.held    = '0;
      kind = ($urandom_range(0, 99) < insert_pct) ? REQ_INSERT : REQ_EXTRACT;
      send_request(kind, random_key(), 1'b0, none);
   endtask

   always @(posedge clock) begin : score_rsp
      heap_rsp_type got;
      heap_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.min_key = rsp_tdata[KEY_W-1:0];
         got.status  = rsp_tdata[KEY_W +: STATUS_W];
         got.held    = rsp_tdata[KEY_W+STATUS_W +: HELD_W];
         if (rsp_due.size() == 0) begin
            $error("response with no request outstanding: min_key %h status %0d held %0d",
                   got.min_key, got.status, got.held);
            mismatch_count++;
         end else begin
            want = rsp_due.pop_front();
            if (got.min_key !== want.min_key) begin
               $error("min_key: expected %h, got %h", want.min_key, got.min_key);
               mismatch_count++;
            end
            if (got.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, got.status);
               mismatch_count++;
            end
            if (got.held !== want.held) begin
               $error("entries_held: expected %0d, got %0d", want.held, got.held);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int climbed;
      add_row(REQ_EXTRACT, 32'hDEADBEEF, 1'b1, '0, STATUS_EMPTY, 11'd0);
      add_row(REQ_INSERT,  32'hFFFFFFFF, 1'b1, '0, STATUS_OK, 11'd1);
      add_row(REQ_INSERT,  32'h00000000, 1'b1, '0, STATUS_OK, 11'd2);
      add_row(REQ_EXTRACT, 32'hFFFFFFFF, 1'b1, 32'h00000000, STATUS_OK, 11'd1);
      add_row(REQ_EXTRACT, 32'h00000000, 1'b1, 32'hFFFFFFFF, STATUS_OK, 11'd0);
      add_row(REQ_EXTRACT, 32'h12345678, 1'b1, '0, STATUS_EMPTY, 11'd0);
      // duplicates exercise the tie rules on both the climb and the sink
      add_row(REQ_INSERT,  32'd7);
      add_row(REQ_INSERT,  32'd7);
      add_row(REQ_INSERT,  32'd3);
      add_row(REQ_INSERT,  32'h80000000);
      add_row(REQ_INSERT,  32'd3);
      add_row(REQ_INSERT,  32'd7);
      add_row(REQ_INSERT,  32'd1);
      add_row(REQ_INSERT,  32'h55555555);
      add_row(REQ_INSERT,  32'hAAAAAAAA);
      for (int i = 0; i < 9; i++)
         add_row(REQ_EXTRACT, {i[15:0], ~i[15:0]});
      add_row(REQ_EXTRACT, 32'hFFFFFFFF, 1'b1, '0, STATUS_EMPTY, 11'd0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_request(directed_rows[i].kind, directed_rows[i].key,
                      directed_rows[i].typed, directed_rows[i].rsp);

      // churn around small sizes
      repeat (30) random_request(55);

      // climb to full; the first stretch runs with no idling on either side
      no_gaps = 1'b1;
      climbed = 0;
      while (heap_size < DEPTH) begin
         if (climbed == 300)
            no_gaps = 1'b0;
         random_request(99);
         climbed++;
      end
      no_gaps = 1'b0;
      repeat (15) random_request(80);

      // pull some keys back out of the full heap
      repeat (20) random_request(20);

      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (64) @(posedge clock);
      if (mismatch_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
